// ===== hdl/msgdf_pkg.sv =====
// Shared constants, types and helpers for the message deframer ring queue.
// Used by msgdf_ltab, msgdf_slots and message_deframer_ring_queue; depends on nothing.
`default_nettype none

package msgdf_pkg;

  localparam int unsigned QUEUE_SLOTS = 16;
  localparam int unsigned SLOT_BYTES  = 32;
  localparam int unsigned TYPE_COUNT  = 32;

  localparam int unsigned SLOT_W  = $clog2(QUEUE_SLOTS);
  localparam int unsigned OFF_W   = $clog2(SLOT_BYTES + 1);
  localparam int unsigned TYPE_W  = $clog2(TYPE_COUNT);
  localparam int unsigned BYTES_N = QUEUE_SLOTS * SLOT_BYTES;
  localparam int unsigned BADDR_W = $clog2(BYTES_N);

  typedef enum logic [1:0] {
    ACT_RECV  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_LOAD  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_e;

  typedef struct packed {
    logic              we;
    logic [TYPE_W-1:0] addr;
    logic [7:0]        data;
  } ltab_wr_t;

  typedef struct packed {
    logic               byte_we;
    logic [BADDR_W-1:0] byte_addr;
    logic [7:0]         byte_data;
    logic               client_we;
    logic [7:0]         client_data;
    logic               length_we;
    logic [OFF_W-1:0]   length_data;
    logic [SLOT_W-1:0]  slot;
  } slot_wr_t;

  typedef struct packed {
    logic               byte_re;
    logic [BADDR_W-1:0] byte_addr;
    logic               hdr_re;
    logic [SLOT_W-1:0]  slot;
  } slot_rd_t;

  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(QUEUE_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

  function automatic logic [BADDR_W-1:0] byte_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [OFF_W-1:0]  off);
    return BADDR_W'(s) * BADDR_W'(SLOT_BYTES) + BADDR_W'(off);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/msgdf_ltab.sv =====
// Loadable type-to-length table: one write port, one registered read port.
// Entries never loaded read as zero through per-entry valid bits. Uses msgdf_pkg.
`default_nettype none

module msgdf_ltab (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  msgdf_pkg::ltab_wr_t                wr_i,
  input  wire                                re_i,
  input  wire  [msgdf_pkg::TYPE_W-1:0]       raddr_i,
  output logic [7:0]                         rdata_o
);

  logic [7:0]                        mem_q [msgdf_pkg::TYPE_COUNT];
  logic [msgdf_pkg::TYPE_COUNT-1:0]  valid_q;
  logic [7:0]                        data_q;
  logic                              vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (re_i) begin
      data_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (wr_i.we) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (re_i) begin
        vld_q <= valid_q[raddr_i];
      end
    end
  end

  // an unloaded type reads as length zero
  assign rdata_o = vld_q ? data_q : 8'd0;

endmodule

`default_nettype wire

// ===== hdl/msgdf_slots.sv =====
// Ring slot storage: message bytes, client id and stored length per slot.
// Synchronous writes, reads registered with enable. Uses msgdf_pkg.
`default_nettype none

module msgdf_slots (
  input  wire                             clk_i,
  input  msgdf_pkg::slot_wr_t             wr_i,
  input  msgdf_pkg::slot_rd_t             rd_i,
  output logic [7:0]                      byte_o,
  output logic [7:0]                      client_o,
  output logic [msgdf_pkg::OFF_W-1:0]     length_o
);

  logic [7:0]                    bytes_q  [msgdf_pkg::BYTES_N];
  logic [7:0]                    client_q [msgdf_pkg::QUEUE_SLOTS];
  logic [msgdf_pkg::OFF_W-1:0]   length_q [msgdf_pkg::QUEUE_SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_i.byte_we) begin
      bytes_q[wr_i.byte_addr] <= wr_i.byte_data;
    end
    if (wr_i.client_we) begin
      client_q[wr_i.slot] <= wr_i.client_data;
    end
    if (wr_i.length_we) begin
      length_q[wr_i.slot] <= wr_i.length_data;
    end
    if (rd_i.byte_re) begin
      byte_o <= bytes_q[rd_i.byte_addr];
    end
    if (rd_i.hdr_re) begin
      client_o <= client_q[rd_i.slot];
      length_o <= length_q[rd_i.slot];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/message_deframer_ring_queue.sv =====
// Top level: type-length deframer feeding a ring of message slots, with pop streaming.
// Depends on msgdf_pkg, msgdf_ltab and msgdf_slots.
//
//  channel | direction | tuser        | tdata (low bit up)                          | tlast
//  s_axis  | in        | action[1:0]  | data_byte, client_id, type_index,           | last_of_buffer
//          |           |              | length_value, zero fill to 32 bits          |
//  m_axis  | out       | kind[1:0]    | out_byte, out_client, out_length,           | last_of_message
//          |           |              | dropped_full, bad_type, partial_dropped,    |
//          |           |              | zero fill to 32 bits                        |
//
// Sequencing: a receive request passes through ST_RX after the registered read of the length table.
// Reset-queue and load-length requests complete in ST_IDLE. A pop reads the slot header in ST_POP_HDR,
// then streams the message bytes in ST_POP_OUT, paced by the slot byte memory read port.
// Reset: rst_ni clears indices, parser state, table valid bits and the output register;
// slot memories need no clearing pass since a pop never reaches an unwritten slot.
// Stalls: the output register holds a result until taken; the parser and pop streamer
// wait on it only when they have a result to place, and a new request is taken only once
// the previous one is finished.
`default_nettype none

module message_deframer_ring_queue (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // data_byte[7:0], client_id[15:8], type_index[20:16],
                                      // length_value[28:21], zero [31:29]
  input  wire  [1:0]  s_axis_tuser,   // action[1:0]
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_byte[7:0], out_client[15:8], out_length[21:16],
                                      // dropped_full[22], bad_type[23], partial_dropped[24],
                                      // zero [31:25]
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  output logic        m_axis_tlast
);

  localparam int unsigned SLOT_W  = msgdf_pkg::SLOT_W;
  localparam int unsigned OFF_W   = msgdf_pkg::OFF_W;
  localparam int unsigned TYPE_W  = msgdf_pkg::TYPE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RX,
    ST_POP_HDR,
    ST_POP_OUT
  } state_e;

  // request fields
  msgdf_pkg::action_e in_action;
  logic [7:0]         in_byte;
  logic [7:0]         in_client;
  logic [4:0]         in_type;
  logic [7:0]         in_len;

  assign in_action = msgdf_pkg::action_e'(s_axis_tuser);
  assign in_byte   = s_axis_tdata[7:0];
  assign in_client = s_axis_tdata[15:8];
  assign in_type   = s_axis_tdata[20:16];
  assign in_len    = s_axis_tdata[28:21];

  state_e              state_q, state_d;
  logic [7:0]          byte_q, byte_d;
  logic [7:0]          client_q, client_d;
  logic                last_q, last_d;
  logic [SLOT_W-1:0]   rs_q, rs_d;
  logic [SLOT_W-1:0]   ws_q, ws_d;
  logic [7:0]          rem_q, rem_d;
  logic [OFF_W-1:0]    woff_q, woff_d;
  logic                storing_q, storing_d;
  logic                skipping_q, skipping_d;
  logic                drop_q, drop_d;
  logic [OFF_W-1:0]    pop_len_q, pop_len_d;
  logic [OFF_W-1:0]    pop_idx_q, pop_idx_d;

  // output register
  logic                out_valid_q, out_valid_d;
  msgdf_pkg::kind_e    out_kind_q, out_kind_d;
  logic [7:0]          out_byte_q, out_byte_d;
  logic [7:0]          out_client_q, out_client_d;
  logic [5:0]          out_len_q, out_len_d;
  logic                out_last_q, out_last_d;
  logic                out_full_q, out_full_d;
  logic                out_bad_q, out_bad_d;
  logic                out_part_q, out_part_d;

  logic                out_free;
  logic                accept;

  msgdf_pkg::ltab_wr_t ltab_wr;
  logic                ltab_re;
  logic [7:0]          ltab_len;
  msgdf_pkg::slot_wr_t slot_wr;
  msgdf_pkg::slot_rd_t slot_rd;
  logic [7:0]          rd_byte;
  logic [7:0]          rd_client;
  logic [OFF_W-1:0]    rd_length;

  // parser scratch values
  logic                go;
  logic                advance;
  logic                bad;
  logic [7:0]          rem_n;
  logic [OFF_W-1:0]    woff_n;
  logic                st_n;
  logic                sk_n;
  logic                dr_n;
  logic [OFF_W-1:0]    idx_n;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  msgdf_ltab u_ltab (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (ltab_wr),
    .re_i    (ltab_re),
    .raddr_i (in_byte[TYPE_W-1:0]),
    .rdata_o (ltab_len)
  );

  msgdf_slots u_slots (
    .clk_i    (clk_i),
    .wr_i     (slot_wr),
    .rd_i     (slot_rd),
    .byte_o   (rd_byte),
    .client_o (rd_client),
    .length_o (rd_length)
  );

  always_comb begin
    state_d      = state_q;
    byte_d       = byte_q;
    client_d     = client_q;
    last_d       = last_q;
    rs_d         = rs_q;
    ws_d         = ws_q;
    rem_d        = rem_q;
    woff_d       = woff_q;
    storing_d    = storing_q;
    skipping_d   = skipping_q;
    drop_d       = drop_q;
    pop_len_d    = pop_len_q;
    pop_idx_d    = pop_idx_q;

    out_valid_d  = out_valid_q && !m_axis_tready;
    out_kind_d   = out_kind_q;
    out_byte_d   = out_byte_q;
    out_client_d = out_client_q;
    out_len_d    = out_len_q;
    out_last_d   = out_last_q;
    out_full_d   = out_full_q;
    out_bad_d    = out_bad_q;
    out_part_d   = out_part_q;

    ltab_wr      = '0;
    ltab_re      = 1'b0;
    slot_wr      = '0;
    slot_wr.slot = ws_q;
    slot_rd      = '0;

    // commit slot writes only while a received byte is being parsed
    go      = (state_q == ST_RX) && (!last_q || out_free);
    advance = 1'b0;
    bad     = (byte_q == 8'd0) || (9'(byte_q) >= 9'(msgdf_pkg::TYPE_COUNT)) ||
              (ltab_len == 8'd0);
    rem_n   = rem_q;
    woff_n  = woff_q;
    st_n    = storing_q;
    sk_n    = skipping_q;
    dr_n    = drop_q;
    idx_n   = pop_idx_q + OFF_W'(1);

    // parse one received byte against the current message state
    if (!skipping_q) begin
      if (rem_q == 8'd0) begin
        if (bad) begin
          sk_n = 1'b1;
        end else begin
          advance = 1'b1;
          woff_n  = '0;
          rem_n   = ltab_len - 8'd1;
          if (msgdf_pkg::slot_next(ws_q) == rs_q) begin
            st_n = 1'b0;
            dr_n = 1'b1;
          end else begin
            st_n                = 1'b1;
            slot_wr.client_we   = go;
            slot_wr.client_data = client_q;
          end
        end
      end else begin
        advance = 1'b1;
        rem_n   = rem_q - 8'd1;
      end
    end
    if (advance && st_n && (woff_n < OFF_W'(msgdf_pkg::SLOT_BYTES))) begin
      slot_wr.byte_we   = go;
      slot_wr.byte_addr = msgdf_pkg::byte_addr(ws_q, woff_n);
      slot_wr.byte_data = byte_q;
      woff_n            = woff_n + OFF_W'(1);
    end
    if (advance && (rem_n == 8'd0)) begin
      if (st_n) begin
        slot_wr.length_we   = go;
        slot_wr.length_data = woff_n;
      end
      st_n   = 1'b0;
      woff_n = '0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            msgdf_pkg::ACT_RECV: begin
              byte_d   = in_byte;
              client_d = in_client;
              last_d   = s_axis_tlast;
              ltab_re  = 1'b1;
              state_d  = ST_RX;
            end
            msgdf_pkg::ACT_POP: begin
              slot_rd.hdr_re    = 1'b1;
              slot_rd.slot      = rs_q;
              slot_rd.byte_re   = 1'b1;
              slot_rd.byte_addr = msgdf_pkg::byte_addr(rs_q, '0);
              state_d           = ST_POP_HDR;
            end
            msgdf_pkg::ACT_CLEAR: begin
              rs_d      = '0;
              ws_d      = '0;
              storing_d = 1'b0;
              woff_d    = '0;
            end
            msgdf_pkg::ACT_LOAD: begin
              // drop loads for types beyond the table
              ltab_wr.we   = (9'(in_type) < 9'(msgdf_pkg::TYPE_COUNT));
              ltab_wr.addr = TYPE_W'(in_type);
              ltab_wr.data = in_len;
            end
            default: begin
            end
          endcase
        end
      end

      ST_RX: begin
        if (go) begin
          // a stored message just completed: advance the write slot
          if (slot_wr.length_we) begin
            ws_d = msgdf_pkg::slot_next(ws_q);
          end
          state_d = ST_IDLE;
          if (last_q) begin
            out_valid_d  = 1'b1;
            out_kind_d   = msgdf_pkg::KIND_STATUS;
            out_byte_d   = 8'd0;
            out_client_d = 8'd0;
            out_len_d    = 6'd0;
            out_last_d   = 1'b1;
            out_full_d   = dr_n;
            out_bad_d    = sk_n;
            out_part_d   = (rem_n != 8'd0);
            // end of buffer: back to expecting a type byte
            rem_d        = 8'd0;
            woff_d       = '0;
            storing_d    = 1'b0;
            skipping_d   = 1'b0;
            drop_d       = 1'b0;
          end else begin
            rem_d        = rem_n;
            woff_d       = woff_n;
            storing_d    = st_n;
            skipping_d   = sk_n;
            drop_d       = dr_n;
          end
        end
      end

      ST_POP_HDR: begin
        if (rs_q == ws_q) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_kind_d   = msgdf_pkg::KIND_EMPTY;
            out_byte_d   = 8'd0;
            out_client_d = 8'd0;
            out_len_d    = 6'd0;
            out_last_d   = 1'b0;
            out_full_d   = 1'b0;
            out_bad_d    = 1'b0;
            out_part_d   = 1'b0;
            state_d      = ST_IDLE;
          end
        end else if (rd_length == '0) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_kind_d   = msgdf_pkg::KIND_BYTE;
            out_byte_d   = 8'd0;
            out_client_d = rd_client;
            out_len_d    = 6'd0;
            out_last_d   = 1'b1;
            out_full_d   = 1'b0;
            out_bad_d    = 1'b0;
            out_part_d   = 1'b0;
            rs_d         = msgdf_pkg::slot_next(rs_q);
            state_d      = ST_IDLE;
          end
        end else begin
          // first byte read is already on its way
          pop_len_d = rd_length;
          pop_idx_d = '0;
          state_d   = ST_POP_OUT;
        end
      end

      ST_POP_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = msgdf_pkg::KIND_BYTE;
          out_byte_d   = rd_byte;
          out_client_d = rd_client;
          out_len_d    = 6'(pop_len_q);
          out_last_d   = (idx_n == pop_len_q);
          out_full_d   = 1'b0;
          out_bad_d    = 1'b0;
          out_part_d   = 1'b0;
          if (idx_n == pop_len_q) begin
            rs_d    = msgdf_pkg::slot_next(rs_q);
            state_d = ST_IDLE;
          end else begin
            slot_rd.byte_re   = 1'b1;
            slot_rd.byte_addr = msgdf_pkg::byte_addr(rs_q, idx_n);
            pop_idx_d         = idx_n;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      byte_q       <= 8'd0;
      client_q     <= 8'd0;
      last_q       <= 1'b0;
      rs_q         <= '0;
      ws_q         <= '0;
      rem_q        <= 8'd0;
      woff_q       <= '0;
      storing_q    <= 1'b0;
      skipping_q   <= 1'b0;
      drop_q       <= 1'b0;
      pop_len_q    <= '0;
      pop_idx_q    <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= msgdf_pkg::KIND_STATUS;
      out_byte_q   <= 8'd0;
      out_client_q <= 8'd0;
      out_len_q    <= 6'd0;
      out_last_q   <= 1'b0;
      out_full_q   <= 1'b0;
      out_bad_q    <= 1'b0;
      out_part_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      byte_q       <= byte_d;
      client_q     <= client_d;
      last_q       <= last_d;
      rs_q         <= rs_d;
      ws_q         <= ws_d;
      rem_q        <= rem_d;
      woff_q       <= woff_d;
      storing_q    <= storing_d;
      skipping_q   <= skipping_d;
      drop_q       <= drop_d;
      pop_len_q    <= pop_len_d;
      pop_idx_q    <= pop_idx_d;
      out_valid_q  <= out_valid_d;
      out_kind_q   <= out_kind_d;
      out_byte_q   <= out_byte_d;
      out_client_q <= out_client_d;
      out_len_q    <= out_len_d;
      out_last_q   <= out_last_d;
      out_full_q   <= out_full_d;
      out_bad_q    <= out_bad_d;
      out_part_q   <= out_part_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'd0, out_part_q, out_bad_q, out_full_q, out_len_q,
                          out_client_q, out_byte_q};

  // write offset never runs past one slot
  a_woff_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    woff_q <= OFF_W'(msgdf_pkg::SLOT_BYTES))
    else $error("write offset beyond slot size");

  // a message being stored always has bytes still to come
  a_storing_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    storing_q |-> (rem_q != 8'd0))
    else $error("storing with no bytes remaining");

  // skipping the rest of a buffer excludes storing a message
  a_skip_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skipping_q |-> !storing_q)
    else $error("storing while skipping");

endmodule

`default_nettype wire
